// ===== sv/dlr_pkg.sv =====
`default_nettype none

package dlr_pkg;

    // Coordinate and fixed-point widths.
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;

    // Running position: integer part one bit wider than a coordinate.
    localparam int POS_W  = COORD_BITS + 1 + FRAC_BITS;
    // Signed increment: magnitude up to 2^FRAC_BITS plus a sign bit.
    localparam int INC_W  = FRAC_BITS + 2;
    // Step count and steps still to take.
    localparam int STEP_W = COORD_BITS + 1;
    // Divider partial remainder, held shifted left by one.
    localparam int REM_W  = COORD_BITS + 2;
    // Divider quotient: one integer bit and FRAC_BITS fraction bits.
    localparam int QUO_W  = FRAC_BITS + 1;
    // Divider step counter, counts FRAC_BITS down to zero.
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    // Operation codes of an input beat.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic div_step;
        logic finish;
        logic advance;
    } dlr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic zero_len;
        logic div_last;
    } dlr_stat_t;

endpackage

`default_nettype wire

// ===== sv/dlr_if.sv =====
`default_nettype none

// Input channel: one beat is a start or an advance request.
interface dlr_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [dlr_pkg::COORD_BITS-1:0]  start_x;
    logic [dlr_pkg::COORD_BITS-1:0]  start_y;
    logic [dlr_pkg::COORD_BITS-1:0]  end_x;
    logic [dlr_pkg::COORD_BITS-1:0]  end_y;

    modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

// Output channel: one beat is one plotted point.
interface dlr_out_if;
    logic                            valid;
    logic                            ready;
    logic [dlr_pkg::COORD_BITS-1:0]  point_x;
    logic [dlr_pkg::COORD_BITS-1:0]  point_y;
    logic                            last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

// ===== sv/dlr_ctrl.sv =====
`default_nettype none

module dlr_ctrl
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    input  wire                      in_op,
    output logic                     in_ready,
    input  wire dlr_pkg::dlr_stat_t  stat,
    output dlr_pkg::dlr_cmd_t        cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // Input is taken only when idle and the output register can take a point.
    assign in_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    // Command decode and next state.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_op == dlr_pkg::OP_START))
                begin
                    cmd.start = 1'b1;
                    if (!stat.zero_len)
                    begin
                        state_next = ST_DIV;
                    end
                end
                else if (accept)
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dlr_dp.sv =====
`default_nettype none

module dlr_dp
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire dlr_pkg::dlr_cmd_t             cmd,
    output dlr_pkg::dlr_stat_t                 stat,
    input  wire [dlr_pkg::COORD_BITS-1:0]      start_x,
    input  wire [dlr_pkg::COORD_BITS-1:0]      start_y,
    input  wire [dlr_pkg::COORD_BITS-1:0]      end_x,
    input  wire [dlr_pkg::COORD_BITS-1:0]      end_y,
    dlr_out_if.source                          out_ch
);

    localparam int CW = dlr_pkg::COORD_BITS;
    localparam int FW = dlr_pkg::FRAC_BITS;

    // Position registers hold the position plus one half, so that the
    // rounded point is a plain bit select.
    logic [dlr_pkg::POS_W-1:0]  pos_x_reg, pos_x_next;
    logic [dlr_pkg::POS_W-1:0]  pos_y_reg, pos_y_next;
    logic [dlr_pkg::INC_W-1:0]  inc_x_reg, inc_x_next;
    logic [dlr_pkg::INC_W-1:0]  inc_y_reg, inc_y_next;
    logic [dlr_pkg::STEP_W-1:0] steps_left_reg, steps_left_next;
    logic                       active_reg, active_next;
    logic [dlr_pkg::REM_W-1:0]  rem_x_reg, rem_x_next;
    logic [dlr_pkg::REM_W-1:0]  rem_y_reg, rem_y_next;
    logic [dlr_pkg::QUO_W-1:0]  quo_x_reg, quo_x_next;
    logic [dlr_pkg::QUO_W-1:0]  quo_y_reg, quo_y_next;
    logic                       neg_x_reg, neg_x_next;
    logic                       neg_y_reg, neg_y_next;
    logic [dlr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [CW-1:0]              out_x_reg, out_x_next;
    logic [CW-1:0]              out_y_reg, out_y_next;
    logic                       out_last_reg, out_last_next;

    // Endpoint differences, taken as magnitude and sign.
    logic          sgn_x, sgn_y;
    logic [CW-1:0] abs_x, abs_y;
    logic [CW-1:0] steps;

    // Divider lanes.
    logic [dlr_pkg::REM_W-1:0] divisor;
    logic                      ge_x, ge_y;
    logic [dlr_pkg::REM_W-1:0] diff_x, diff_y;

    // Advance sums.
    logic [dlr_pkg::POS_W-1:0] add_x, add_y;
    logic                      last_step;

    assign sgn_x = end_x < start_x;
    assign sgn_y = end_y < start_y;
    assign abs_x = sgn_x ? (start_x - end_x) : (end_x - start_x);
    assign abs_y = sgn_y ? (start_y - end_y) : (end_y - start_y);
    assign steps = (abs_x > abs_y) ? abs_x : abs_y;

    // One restoring division step per cycle on both lanes.
    assign divisor = {1'b0, steps_left_reg};
    assign ge_x    = rem_x_reg >= divisor;
    assign ge_y    = rem_y_reg >= divisor;
    assign diff_x  = ge_x ? (rem_x_reg - divisor) : rem_x_reg;
    assign diff_y  = ge_y ? (rem_y_reg - divisor) : rem_y_reg;

    // Position plus sign-extended increment.
    assign add_x = pos_x_reg
        + {{(dlr_pkg::POS_W - dlr_pkg::INC_W){inc_x_reg[dlr_pkg::INC_W-1]}}, inc_x_reg};
    assign add_y = pos_y_reg
        + {{(dlr_pkg::POS_W - dlr_pkg::INC_W){inc_y_reg[dlr_pkg::INC_W-1]}}, inc_y_reg};
    assign last_step = steps_left_reg == dlr_pkg::STEP_W'(1);

    assign stat.out_free = !out_valid_reg || out_ch.ready;
    assign stat.zero_len = (steps == '0);
    assign stat.div_last = (cnt_reg == '0);

    // Next-state logic for all datapath registers.
    always_comb
    begin
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        steps_left_next = steps_left_reg;
        active_next     = active_reg;
        rem_x_next      = rem_x_reg;
        rem_y_next      = rem_y_reg;
        quo_x_next      = quo_x_reg;
        quo_y_next      = quo_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_last_next   = out_last_reg;

        if (cmd.start)
        begin
            // Load the start point and set up the division.
            pos_x_next      = {1'b0, start_x, 1'b1, {(FW - 1){1'b0}}};
            pos_y_next      = {1'b0, start_y, 1'b1, {(FW - 1){1'b0}}};
            inc_x_next      = '0;
            inc_y_next      = '0;
            steps_left_next = {1'b0, steps};
            active_next     = 1'b0;
            rem_x_next      = {2'b00, abs_x};
            rem_y_next      = {2'b00, abs_y};
            quo_x_next      = '0;
            quo_y_next      = '0;
            neg_x_next      = sgn_x;
            neg_y_next      = sgn_y;
            cnt_next        = dlr_pkg::CNT_W'(FW);
            out_valid_next  = 1'b1;
            out_x_next      = start_x;
            out_y_next      = start_y;
            out_last_next   = (steps == '0);
        end
        else if (cmd.div_step)
        begin
            rem_x_next = {diff_x[dlr_pkg::REM_W-2:0], 1'b0};
            rem_y_next = {diff_y[dlr_pkg::REM_W-2:0], 1'b0};
            quo_x_next = {quo_x_reg[dlr_pkg::QUO_W-2:0], ge_x};
            quo_y_next = {quo_y_reg[dlr_pkg::QUO_W-2:0], ge_y};
            cnt_next   = cnt_reg - dlr_pkg::CNT_W'(1);
        end
        else if (cmd.finish)
        begin
            // Apply the sign of the difference to the quotient.
            inc_x_next  = neg_x_reg ? (dlr_pkg::INC_W'(0) - {1'b0, quo_x_reg})
                                    : {1'b0, quo_x_reg};
            inc_y_next  = neg_y_reg ? (dlr_pkg::INC_W'(0) - {1'b0, quo_y_reg})
                                    : {1'b0, quo_y_reg};
            active_next = 1'b1;
        end
        else if (cmd.advance && active_reg)
        begin
            // Step along the line and emit the rounded point.
            pos_x_next      = add_x;
            pos_y_next      = add_y;
            steps_left_next = steps_left_reg - dlr_pkg::STEP_W'(1);
            active_next     = !last_step;
            out_valid_next  = 1'b1;
            out_x_next      = add_x[FW +: CW];
            out_y_next      = add_y[FW +: CW];
            out_last_next   = last_step;
        end
    end

    // Register bank.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            inc_x_reg      <= '0;
            inc_y_reg      <= '0;
            steps_left_reg <= '0;
            active_reg     <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            inc_x_reg      <= inc_x_next;
            inc_y_reg      <= inc_y_next;
            steps_left_reg <= steps_left_next;
            active_reg     <= active_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Divider working registers and output payload.
    always_ff @(posedge clk)
    begin
        rem_x_reg    <= rem_x_next;
        rem_y_reg    <= rem_y_next;
        quo_x_reg    <= quo_x_next;
        quo_y_reg    <= quo_y_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.point_x    = out_x_reg;
    assign out_ch.point_y    = out_y_reg;
    assign out_ch.last_point = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/dda_line_rasterizer.sv =====
// A point appears on the output in the cycle after its input beat is taken; an
// advance beat with no line in progress gives no point. Advance beats are taken one
// per cycle while no start is being divided and the output keeps draining. A start
// beat loads the line, runs the bit-serial increment divider, then signs the increments.
// Reset (rst_n low, asynchronous) clears the position, increments and step count,
// ends any line in progress and empties the output register.
`default_nettype none

module dda_line_rasterizer
(
    input  wire         clk,
    input  wire         rst_n,
    dlr_in_if.sink      in_ch,
    dlr_out_if.source   out_ch
);

    dlr_pkg::dlr_cmd_t  cmd;
    dlr_pkg::dlr_stat_t stat;
    logic               in_ready;

    // Sequencer for start, divide and advance.
    dlr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Position, increment, divider and output register.
    dlr_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .start_x (in_ch.start_x),
        .start_y (in_ch.start_y),
        .end_x   (in_ch.end_x),
        .end_y   (in_ch.end_y),
        .out_ch  (out_ch)
    );

    assign in_ch.ready = in_ready;

`ifndef SYNTH
    // The controller issues at most one command per cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.div_step, cmd.finish, cmd.advance}))
        else $error("more than one datapath command at once");

    // A start beat always yields a point on the next cycle.
    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.op == dlr_pkg::OP_START)) |=> out_ch.valid)
        else $error("start beat produced no point");

    // A start with equal endpoints gives a single final point.
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.op == dlr_pkg::OP_START)
         && (in_ch.start_x == in_ch.end_x) && (in_ch.start_y == in_ch.end_y))
        |=> out_ch.last_point)
        else $error("zero-length line not marked as last");

    // No input is taken while the divider is running.
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.finish) |-> !in_ch.ready)
        else $error("input taken during division");
`endif

endmodule

`default_nettype wire
